FILE: sv/txc_pkg.sv
// Shared types and constants for the text console engine.
// No dependencies; imported by the engine top, txc_cursor and the testbench.
package txc_pkg;

  // Default geometry, handed to the top level as parameter defaults
  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STOP_DEF = 8;

  // Item modes
  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Character codes with special handling
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BLANK = 8'h20;

  // Attribute after reset: white on black
  localparam logic [7:0] ATTR_RESET = 8'h0F;

  // Actions a put asks of the store sequencer
  typedef struct packed {
    logic cell_wr;  // write the character at the old cursor position
    logic scroll;   // cursor ran off the bottom, scroll the store up a row
  } txc_put_t;

endpackage

FILE: sv/text_console_cursor_engine.sv
// Text console engine top: cell store sequencer, cursor registers, result beat.
// Depends on txc_pkg, txc_ram and txc_cursor.
//
// Keeps a ROWS x COLUMNS store of 16-bit cells (attribute high, character low)
// in one synchronous RAM and a cursor in registers. A put that does not scroll
// or an unused mode goes from accept through S_EMIT to the result register; a
// read passes S_READ first (one RAM read). A put that scrolls walks the RAM at
// one cell per cycle: (ROWS-1)*COLUMNS copies plus COLUMNS blank fills. A clear
// fills every cell. After reset the block clears the store to zero before
// in_ready rises; attribute writes are taken throughout. The single RAM write
// port sets the pace of these walks. A finished result sits in the output
// register while the next item is accepted.
module text_console_cursor_engine #(
  parameter int COLUMNS  = txc_pkg::COLUMNS_DEF,
  parameter int ROWS     = txc_pkg::ROWS_DEF,
  parameter int TAB_STOP = txc_pkg::TAB_STOP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // item input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_char_code,
  input  logic [10:0] in_cell_address,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] out_cursor_offset,
  output logic [15:0] out_read_cell,
  // attribute register
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import txc_pkg::*;

  localparam int CELLS     = ROWS * COLUMNS;
  localparam int LAST_BASE = (ROWS - 1) * COLUMNS;
  localparam int RESET_ROW = (ROWS > 10) ? 10 : ROWS - 1;
  localparam int AW        = $clog2(CELLS);
  localparam int CW        = $clog2(COLUMNS);
  localparam int RW        = $clog2(ROWS);
  localparam int PW        = $clog2(TAB_STOP);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCROLL,
    S_FILL,
    S_EMIT
  } state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [PW-1:0]  phase_r, phase_nxt;
  logic [7:0]     attr_r, attr_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic           cp_valid_r, cp_valid_nxt;
  logic [AW-1:0]  cp_addr_r, cp_addr_nxt;
  logic           fill_zero_r, fill_zero_nxt;
  logic           rd_ok_r, rd_ok_nxt;
  logic [15:0]    res_data_r, res_data_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [10:0]    out_offset_r, out_offset_nxt;
  logic [15:0]    out_cell_r, out_cell_nxt;

  logic           accept;
  logic [AW-1:0]  cur_addr;
  logic           ram_we;
  logic [AW-1:0]  ram_wr_addr;
  logic [15:0]    ram_wr_data;
  logic [AW-1:0]  ram_rd_addr;
  logic [15:0]    ram_rd_data;
  logic [15:0]    fill_word;

  logic [CW-1:0]  put_col;
  logic [RW-1:0]  put_row;
  logic [PW-1:0]  put_phase;
  txc_put_t       put_act;

  // Cell store
  txc_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Next cursor for a put
  txc_cursor #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_cursor (
    .cur_col   (col_r),
    .cur_row   (row_r),
    .cur_phase (phase_r),
    .char_code (in_char_code),
    .nxt_col   (put_col),
    .nxt_row   (put_row),
    .nxt_phase (put_phase),
    .put_act   (put_act)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign cur_addr  = AW'(row_r) * AW'(COLUMNS) + AW'(col_r);
  assign fill_word = fill_zero_r ? 16'h0000 : {attr_r, CH_BLANK};

  // Sequencer: RAM port control and next-state logic
  always_comb begin
    state_nxt      = state_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    phase_nxt      = phase_r;
    attr_nxt       = cfg_wr_en ? cfg_wr_data : attr_r;
    idx_nxt        = idx_r;
    cp_valid_nxt   = 1'b0;
    cp_addr_nxt    = cp_addr_r;
    fill_zero_nxt  = fill_zero_r;
    rd_ok_nxt      = rd_ok_r;
    res_data_nxt   = res_data_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_offset_nxt = out_offset_r;
    out_cell_nxt   = out_cell_r;
    ram_we         = 1'b0;
    ram_wr_addr    = cur_addr;
    ram_wr_data    = {attr_r, in_char_code};
    ram_rd_addr    = AW'(in_cell_address);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_data_nxt = '0;
          state_nxt    = S_EMIT;
          unique case (in_mode)
            MODE_PUT: begin
              ram_we    = put_act.cell_wr;
              col_nxt   = put_col;
              row_nxt   = put_row;
              phase_nxt = put_phase;
              if (put_act.scroll) begin
                idx_nxt   = '0;
                state_nxt = S_SCROLL;
              end
            end
            MODE_CLEAR: begin
              col_nxt       = '0;
              row_nxt       = '0;
              phase_nxt     = '0;
              idx_nxt       = '0;
              fill_zero_nxt = 1'b0;
              state_nxt     = S_FILL;
            end
            MODE_READ: begin
              rd_ok_nxt = (32'(in_cell_address) < 32'(CELLS));
              state_nxt = S_READ;
            end
            default: begin
              // unused mode: result only
              state_nxt = S_EMIT;
            end
          endcase
        end
      end

      S_READ: begin
        res_data_nxt = rd_ok_r ? ram_rd_data : '0;
        state_nxt    = S_EMIT;
      end

      // copy row r+1 to row r, read one cell ahead of the write
      S_SCROLL: begin
        ram_rd_addr  = idx_r + AW'(COLUMNS);
        ram_we       = cp_valid_r;
        ram_wr_addr  = cp_addr_r;
        ram_wr_data  = ram_rd_data;
        cp_valid_nxt = 1'b1;
        cp_addr_nxt  = idx_r;
        if (idx_r == AW'(LAST_BASE - 1)) begin
          idx_nxt       = AW'(LAST_BASE);
          fill_zero_nxt = 1'b0;
          state_nxt     = S_FILL;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      // blank fill (zero after reset) up to the last cell; a trailing copy write goes first
      S_FILL: begin
        ram_we = 1'b1;
        if (cp_valid_r) begin
          ram_wr_addr = cp_addr_r;
          ram_wr_data = ram_rd_data;
        end else begin
          ram_wr_addr = idx_r;
          ram_wr_data = fill_word;
          if (idx_r == AW'(CELLS - 1)) begin
            fill_zero_nxt = 1'b0;
            state_nxt     = fill_zero_r ? S_IDLE : S_EMIT;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
      end

      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_offset_nxt = 11'(cur_addr);
          out_cell_nxt   = res_data_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      col_r       <= '0;
      row_r       <= RW'(RESET_ROW);
      phase_r     <= '0;
      attr_r      <= ATTR_RESET;
      idx_r       <= '0;
      cp_valid_r  <= 1'b0;
      fill_zero_r <= 1'b1;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      phase_r     <= phase_nxt;
      attr_r      <= attr_nxt;
      idx_r       <= idx_nxt;
      cp_valid_r  <= cp_valid_nxt;
      fill_zero_r <= fill_zero_nxt;
      rd_ok_r     <= rd_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cp_addr_r    <= cp_addr_nxt;
    res_data_r   <= res_data_nxt;
    out_offset_r <= out_offset_nxt;
    out_cell_r   <= out_cell_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_cursor_offset = out_offset_r;
  assign out_read_cell     = out_cell_r;

  // Cursor never leaves the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(col_r) < 32'(COLUMNS)) && (32'(row_r) < 32'(ROWS)))
    else $error("cursor out of range");

  // Every store write lands inside the screen
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (32'(ram_wr_addr) < 32'(CELLS)))
    else $error("store write out of range");

  // A pending copy write only lives across the scroll and fill walks
  a_copy_phase: assert property (@(posedge clk) disable iff (!rst_n)
    cp_valid_r |-> (state_r == S_SCROLL || state_r == S_FILL))
    else $error("copy write outside scroll");

  // One item at a time: an accepted beat closes the input
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("second beat accepted while busy");

endmodule

FILE: sv/txc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module txc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/txc_cursor.sv
// Cursor update for one put: control codes, printable advance, wrap, scroll.
// Depends on txc_pkg for character codes and the action struct.
module txc_cursor #(
  parameter int COLUMNS  = txc_pkg::COLUMNS_DEF,
  parameter int ROWS     = txc_pkg::ROWS_DEF,
  parameter int TAB_STOP = txc_pkg::TAB_STOP_DEF
) (
  input  logic [$clog2(COLUMNS)-1:0]  cur_col,
  input  logic [$clog2(ROWS)-1:0]     cur_row,
  input  logic [$clog2(TAB_STOP)-1:0] cur_phase,
  input  logic [7:0]                  char_code,
  output logic [$clog2(COLUMNS)-1:0]  nxt_col,
  output logic [$clog2(ROWS)-1:0]     nxt_row,
  output logic [$clog2(TAB_STOP)-1:0] nxt_phase,
  output txc_pkg::txc_put_t           put_act
);
  import txc_pkg::*;

  localparam int CW  = $clog2(COLUMNS);
  localparam int RW  = $clog2(ROWS);
  localparam int PW  = $clog2(TAB_STOP);
  // Column can briefly reach COLUMNS-1+TAB_STOP, row can reach ROWS
  localparam int XW  = $clog2(COLUMNS + TAB_STOP);
  localparam int RXW = $clog2(ROWS + 1);

  logic [XW-1:0]  col_x;
  logic [RXW-1:0] row_x;
  logic [PW-1:0]  ph_x;

  // phase tracks column modulo the tab stop, so a tab is one add
  always_comb begin
    col_x   = XW'(cur_col);
    row_x   = RXW'(cur_row);
    ph_x    = cur_phase;
    put_act = '0;

    priority if (char_code == CH_BS) begin
      if (cur_col != '0) begin
        col_x = col_x - XW'(1);
        ph_x  = (cur_phase == '0) ? PW'(TAB_STOP - 1) : cur_phase - PW'(1);
      end
    end else if (char_code == CH_TAB) begin
      col_x = col_x + XW'(TAB_STOP) - XW'(cur_phase);
      ph_x  = '0;
    end else if (char_code == CH_CR) begin
      col_x = '0;
      ph_x  = '0;
    end else if (char_code == CH_LF) begin
      col_x = '0;
      ph_x  = '0;
      row_x = row_x + RXW'(1);
    end else if (char_code >= CH_BLANK) begin
      put_act.cell_wr = 1'b1;
      col_x = col_x + XW'(1);
      ph_x  = (cur_phase == PW'(TAB_STOP - 1)) ? '0 : cur_phase + PW'(1);
    end else begin
      // other control codes: no effect
      col_x = XW'(cur_col);
    end

    // wrap at the right edge
    if (col_x >= XW'(COLUMNS)) begin
      col_x = '0;
      ph_x  = '0;
      row_x = row_x + RXW'(1);
    end

    // bottom edge: scroll and stay on the last row
    if (row_x >= RXW'(ROWS)) begin
      put_act.scroll = 1'b1;
      row_x = RXW'(ROWS - 1);
    end
  end

  assign nxt_col   = CW'(col_x);
  assign nxt_row   = RW'(row_x);
  assign nxt_phase = ph_x;

endmodule

FILE: verif/text_console_cursor_engine_tb.sv
// Testbench for text_console_cursor_engine: directed and random put/clear/read beats
// checked against a shadow copy of the screen store, cursor and attribute.
// Depends on txc_pkg and the text_console_cursor_engine RTL.
`timescale 1ns / 1ps

module text_console_cursor_engine_tb;
  import txc_pkg::*;

  localparam int N_COLS   = COLUMNS_DEF;
  localparam int N_ROWS   = ROWS_DEF;
  localparam int TAB_W    = TAB_STOP_DEF;
  localparam int N_CELLS  = N_ROWS * N_COLS;
  localparam int HOME_ROW = (N_ROWS > 10) ? 10 : N_ROWS - 1;

  // mode code with no action
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // scrolls and clears walk the whole store, so keep their number bounded
  localparam int HEAVY_BUDGET  = 150;
  localparam int PHASE_ITEMS   = 460;
  localparam int ATTR_INTERVAL = 150;
  localparam int PRESSURE_HOLD = 300;
  localparam int BURST_ITEMS   = 24;
  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [10:0] cursor_offset;
    logic [15:0] read_cell;
  } console_beat_t;

  // Shadow of the console: updated per accepted item, holds expected result beats
  class console_shadow;
    logic [15:0]   cells [N_CELLS];
    logic [6:0]    cur_col;
    logic [4:0]    cur_row;
    logic [7:0]    attr;
    console_beat_t awaited[$];
    int            n_errors;
    int            n_reported;

    function new();
      foreach (cells[i]) cells[i] = 16'h0000;
      cur_col    = '0;
      cur_row    = 5'(HOME_ROW);
      attr       = ATTR_RESET;
      n_errors   = 0;
      n_reported = 0;
    endfunction

    // true when a put of this code would push the cursor off the bottom
    function bit put_scrolls(logic [7:0] code);
      int col;
      col = cur_col;
      if (cur_row != N_ROWS - 1) return 0;
      if (code == CH_LF) return 1;
      if (code == CH_TAB) return ((col / TAB_W + 1) * TAB_W) >= N_COLS;
      if (code >= CH_BLANK) return (col + 1) >= N_COLS;
      return 0;
    endfunction

    function void apply_put(logic [7:0] code);
      int col;
      int row;
      col = cur_col;
      row = cur_row;
      if (code == CH_BS) begin
        if (col != 0) col--;
      end else if (code == CH_TAB) begin
        col = (col / TAB_W + 1) * TAB_W;
      end else if (code == CH_CR) begin
        col = 0;
      end else if (code == CH_LF) begin
        col = 0;
        row++;
      end else if (code >= CH_BLANK) begin
        cells[row * N_COLS + col] = {attr, code};
        col++;
      end
      // wrap, then scroll on running off the last row
      if (col >= N_COLS) begin
        col = 0;
        row++;
      end
      if (row >= N_ROWS) begin
        for (int i = 0; i < (N_ROWS - 1) * N_COLS; i++) cells[i] = cells[i + N_COLS];
        for (int i = (N_ROWS - 1) * N_COLS; i < N_CELLS; i++) cells[i] = {attr, CH_BLANK};
        row = N_ROWS - 1;
      end
      cur_col = 7'(col);
      cur_row = 5'(row);
    endfunction

    // note one accepted input beat and queue the result it must produce
    function void accept_item(logic [1:0] mode, logic [7:0] code, logic [10:0] addr);
      console_beat_t beat;
      beat.read_cell = 16'h0000;
      if (mode == MODE_PUT) begin
        apply_put(code);
      end else if (mode == MODE_CLEAR) begin
        foreach (cells[i]) cells[i] = {attr, CH_BLANK};
        cur_col = '0;
        cur_row = '0;
      end else if (mode == MODE_READ) begin
        if (addr < N_CELLS) beat.read_cell = cells[addr];
      end
      beat.cursor_offset = 11'(int'(cur_row) * N_COLS + int'(cur_col));
      awaited.push_back(beat);
    endfunction

    // compare one result beat with the oldest expectation
    function void check_result(logic [10:0] offset, logic [15:0] rd);
      console_beat_t exp_beat;
      if (awaited.size() == 0) begin
        n_errors++;
        if (n_reported < MAX_REPORTS) begin
          n_reported++;
          $display("%0t: unexpected result beat offset=%0d cell=%h", $realtime, offset, rd);
        end
        return;
      end
      exp_beat = awaited.pop_front();
      if (offset !== exp_beat.cursor_offset || rd !== exp_beat.read_cell) begin
        n_errors++;
        if (n_reported < MAX_REPORTS) begin
          n_reported++;
          $display("%0t: mismatch offset exp=%0d got=%0d, read_cell exp=%h got=%h",
                   $realtime, exp_beat.cursor_offset, offset, exp_beat.read_cell, rd);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_mode;
  logic [7:0]  in_char_code;
  logic [10:0] in_cell_address;
  logic        out_valid;
  logic        out_ready;
  logic [10:0] out_cursor_offset;
  logic [15:0] out_read_cell;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;

  console_shadow shadow = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int heavy_ops     = 0;

  always #1 clk = ~clk;

  text_console_cursor_engine uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_char_code      (in_char_code),
    .in_cell_address   (in_cell_address),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cursor_offset (out_cursor_offset),
    .out_read_cell     (out_read_cell),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  // Offer one input beat after a random gap and wait until it is taken
  task automatic send_item(input logic [1:0] mode, input logic [7:0] code,
                           input logic [10:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_char_code    <= code;
    in_cell_address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    shadow.accept_item(mode, code, addr);
  endtask

  // Attribute writes only once every outstanding result has come back
  task automatic write_attribute(input logic [7:0] value);
    in_valid <= 1'b0;
    while (shadow.awaited.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow.attr = value;
  endtask

  // Mostly printable text with line control, some reads, rare clears
  task automatic send_random_item();
    logic [1:0]  mode;
    logic [7:0]  code;
    logic [10:0] addr;
    int          pick;
    code = 8'($urandom);
    addr = 11'($urandom);
    pick = $urandom_range(99);
    if (pick < 16) begin
      mode = MODE_READ;
      if (pick < 2) addr = 11'($urandom_range(2047, N_CELLS));
      else addr = 11'($urandom_range(N_CELLS - 1));
    end else if (pick < 17) begin
      mode = MODE_CLEAR;
    end else if (pick < 18) begin
      mode = MODE_UNUSED;
    end else begin
      mode = MODE_PUT;
      pick = $urandom_range(99);
      if (pick < 8) code = CH_LF;
      else if (pick < 12) code = CH_TAB;
      else if (pick < 15) code = CH_BS;
      else if (pick < 18) code = CH_CR;
      else if (pick < 21) code = 8'($urandom_range(31));
      else code = 8'($urandom_range(255, 32));
    end
    // past the budget, a walk of the store becomes a carriage return
    if (mode == MODE_CLEAR || (mode == MODE_PUT && shadow.put_scrolls(code))) begin
      if (heavy_ops < HEAVY_BUDGET) begin
        heavy_ops++;
      end else begin
        mode = MODE_PUT;
        code = CH_CR;
      end
    end
    send_item(mode, code, addr);
  endtask

  // Result side: check accepted beats, random stalls, long hold-off on request
  initial begin : result_sink
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) shadow.check_result(out_cursor_offset, out_read_cell);
      if (hold_left == 0 && holds_served != hold_requests) begin
        holds_served++;
        hold_left = PRESSURE_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Run limit
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("text_console_cursor_engine_tb: errors");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_mode         <= MODE_PUT;
    in_char_code    <= 8'h00;
    in_cell_address <= 11'd0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= 8'h00;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset attribute, every put case, field extremes
    send_item(MODE_READ, 8'h00, 11'd0);
    send_item(MODE_READ, 8'hFF, 11'h7FF);
    send_item(MODE_UNUSED, 8'hFF, 11'h7FF);
    send_item(MODE_PUT, CH_BS, 11'd0);
    send_item(MODE_PUT, 8'h41, 11'd0);
    send_item(MODE_PUT, 8'hFF, 11'd0);
    send_item(MODE_PUT, CH_BS, 11'd0);
    send_item(MODE_PUT, CH_TAB, 11'd0);
    send_item(MODE_PUT, CH_BLANK, 11'd0);
    send_item(MODE_PUT, CH_CR, 11'd0);
    send_item(MODE_PUT, CH_LF, 11'd0);
    send_item(MODE_PUT, 8'h00, 11'd0);
    send_item(MODE_PUT, 8'h1F, 11'd0);
    send_item(MODE_READ, 8'h00, 11'(HOME_ROW * N_COLS));
    write_attribute(8'h00);
    send_item(MODE_PUT, 8'h7E, 11'd0);
    send_item(MODE_READ, 8'h00, 11'((HOME_ROW + 1) * N_COLS));
    write_attribute(8'hFF);
    heavy_ops++;
    send_item(MODE_CLEAR, 8'h00, 11'd0);
    send_item(MODE_READ, 8'h00, 11'(N_CELLS - 1));
    send_item(MODE_READ, 8'h00, 11'(N_CELLS));
    send_item(MODE_PUT, 8'h80, 11'd0);

    // random: three idling phases, attribute changed every so often
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 78 : 0;
      recv_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 37 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % ATTR_INTERVAL == 0) write_attribute(8'($urandom));
        if (phase == 2 && n == 100) begin
          // receiver stalls long while the sender keeps offering
          hold_requests <= hold_requests + 1;
          for (int b = 0; b < BURST_ITEMS; b++) send_random_item();
        end
        send_random_item();
      end
    end
    in_valid <= 1'b0;

    // drain
    while (shadow.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.n_errors == 0 && shadow.awaited.size() == 0) begin
      $display("text_console_cursor_engine_tb: clean");
    end else begin
      $display("text_console_cursor_engine_tb: errors");
    end
    $finish;
  end

endmodule
